>>> hdl/mer_pkg.sv
// Shared constants, codes and types for the midpoint ellipse rasterizer.
// No dependencies; every other file but mer_mul uses this package.
package mer_pkg;

   localparam int unsigned COORD_BITS_DEF = 12;
   localparam int unsigned COLOR_W        = 24;
   localparam int unsigned DEC_W          = 48;   // decision value, 2 fractional bits
   localparam int unsigned DEC_PW         = 50;   // working width before the /4 floor

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } mer_cmd_type;

   // Control half of a pixel burst handed from the sequencer to the emitter.
   typedef struct packed {
      logic two_pt;     // start burst: two points on the y axis
      logic finished;   // ellipse completes with this burst
   } mer_burst_ctl_type;

endpackage

>>> hdl/mer_ifs.sv
// Request and response channel interfaces of the ellipse rasterizer.
// Depends on mer_pkg for default widths.
interface mer_req_if #(
   parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [COORD_BITS-1:0] corner_a_x;
   logic [COORD_BITS-1:0] corner_a_y;
   logic [COORD_BITS-1:0] corner_b_x;
   logic [COORD_BITS-1:0] corner_b_y;

   modport source (output valid, command, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                   input ready);
   modport sink   (input valid, command, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                   output ready);
endinterface

interface mer_rsp_if #(
   parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic [COORD_BITS-1:0]       pixel_x;
   logic [COORD_BITS-1:0]       pixel_y;
   logic [mer_pkg::COLOR_W-1:0] color;
   logic                        last_of_step;
   logic                        finished;

   modport source (output valid, pixel_x, pixel_y, color, last_of_step, finished,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, color, last_of_step, finished,
                   output ready);
endinterface

>>> hdl/mer_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing but its parameters; used by the rasterizer sequencer.
module mer_mul #(
   parameter int unsigned MUL_W  = 27,
   parameter int unsigned PROD_W = 50
) (
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   logic signed [2*MUL_W-1:0] full;

   assign full = op_a * op_b;

   // product is kept modulo 2^PROD_W (sign-extended when narrower)
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(full);
   end

endmodule

>>> hdl/mer_emit.sv
// Pixel emitter: expands one burst (center, offsets) into 2 or 4 pixels.
// Depends on mer_pkg and mer_rsp_if.
module mer_emit #(
   parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            launch,
   input  mer_pkg::mer_burst_ctl_type      ctl,
   input  logic [COORD_BITS:0]             center_x_half,
   input  logic [COORD_BITS:0]             center_y_half,
   input  logic [COORD_BITS-1:0]           offset_x,
   input  logic [COORD_BITS:0]             offset_y_half,
   input  logic [mer_pkg::COLOR_W-1:0]     color,
   output logic                            idle,
   mer_rsp_if.source                       rsp_chan
);
   import mer_pkg::*;

   localparam int unsigned CW = COORD_BITS;

   logic                busy_ff, busy_in;
   logic [1:0]          cnt_ff, cnt_in;
   mer_burst_ctl_type   ctl_ff;
   logic [CW:0]         cx_ff, cy_ff, y_ff;
   logic [CW-1:0]       x_ff;

   logic                neg_x, neg_y, last;
   logic [CW+2:0]       cx_e, sx_e, cy_e, sy_e;
   logic signed [CW+2:0] hx, hy;

   // half-pixel value to pixel, truncating toward zero, kept to CW bits
   function automatic logic [CW-1:0] to_pixel(input logic [CW+2:0] h);
      return h[CW:1] + CW'(h[CW+2] & h[0]);
   endfunction

   assign cx_e  = {2'b00, cx_ff};
   assign sx_e  = {2'b00, x_ff, 1'b0};
   assign cy_e  = {2'b00, cy_ff};
   assign sy_e  = {2'b00, y_ff};

   // quadrant order: (+,+) (-,+) (-,-) (+,-); start burst is (0,+) (0,-)
   assign neg_x = ctl_ff.two_pt ? 1'b0 : (cnt_ff[0] ^ cnt_ff[1]);
   assign neg_y = ctl_ff.two_pt ? cnt_ff[0] : cnt_ff[1];
   assign last  = ctl_ff.two_pt ? (cnt_ff == 2'd1) : (cnt_ff == 2'd3);

   assign hx = neg_x ? signed'(cx_e - sx_e) : signed'(cx_e + sx_e);
   assign hy = neg_y ? signed'(cy_e - sy_e) : signed'(cy_e + sy_e);

   assign rsp_chan.valid        = busy_ff;
   assign rsp_chan.pixel_x      = to_pixel(hx);
   assign rsp_chan.pixel_y      = to_pixel(hy);
   assign rsp_chan.color        = color;
   assign rsp_chan.last_of_step = last;
   assign rsp_chan.finished     = ctl_ff.finished;
   assign idle                  = ~busy_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (launch) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
      end else if (busy_ff && rsp_chan.ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         ctl_ff <= ctl;
         cx_ff  <= center_x_half;
         cy_ff  <= center_y_half;
         x_ff   <= offset_x;
         y_ff   <= offset_y_half;
      end
   end

endmodule

>>> hdl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer top level: sequencer, ellipse state, CSR.
// Depends on mer_pkg, mer_ifs (mer_req_if, mer_rsp_if), mer_mul and mer_emit.

// A start request (command 0) takes two bounding-box corners, derives the center and
// the half-axis radii in half-pixel units, and produces the two pixels at x offset 0.
// Each step request (command 1) advances the midpoint ellipse by one iteration and
// produces its four symmetric pixels; a step with no ellipse active produces nothing.
// Every pixel carries the csr color, last_of_step marks the final pixel of a request
// and finished is set on all pixels of the request that completes the ellipse.
// All products go through one registered multiplier, stepped by a small sequencer,
// so how long a request occupies the block, from acceptance to ready again, is set
// by how many products it needs. The pixels then drain one per cycle from the
// emitter while the sink is ready, and the next request is already being worked on;
// the sequencer only waits for the emitter when it hands over the next burst.
// csr_wdata is taken into the color register on any clock with csr_we high, and
// should only be written while no pixels are outstanding.
module midpoint_ellipse_rasterizer #(
   parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [mer_pkg::COLOR_W-1:0] csr_wdata,
   mer_req_if.sink                     req_chan,
   mer_rsp_if.source                   rsp_chan
);
   import mer_pkg::*;

   localparam int unsigned CW    = COORD_BITS;
   localparam int unsigned HW    = CW + 1;        // half-pixel coordinates
   localparam int unsigned SQW   = 2 * CW;        // squared radii
   localparam int unsigned MUL_W = 2 * CW + 3;    // signed multiplier operand

   localparam logic signed [HW:0] ONE_S   = (HW+1)'(1);
   localparam logic signed [HW:0] TWO_S   = (HW+1)'(2);
   localparam logic signed [HW:0] THREE_S = (HW+1)'(3);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_R1   = 2'd1,
      PH_R2   = 2'd2
   } phase_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ST_A2,    // A*A
      S_ST_B2,    // B*B
      S_ST_AB,    // A^2*B
      S_ST_DEC,   // start decision value
      S_TST1,     // region-one test, left side A^2(Y-1)
      S_TST2,     // right side B^2(x+1)
      S_TST3,     // compare
      S_R1_M1,    // B^2(2x+3)
      S_R1_M2,    // A^2(2-Y)
      S_R1_UPD,
      S_SW_1,     // (2x+1)^2
      S_SW_2,     // B^2(2x+1)^2
      S_SW_3,     // (Y-2)^2
      S_SW_4,     // A^2(Y-2)^2
      S_SW_5,     // A^2*B^2
      S_SW_6,     // region-two decision value
      S_R2_CHK,   // A^2(3-Y)
      S_R2_M2,    // B^2(x+1)
      S_R2_UPD,
      S_LAUNCH    // hand the burst to the emitter
   } seq_state_type;

   // ---------------- control state ----------------
   seq_state_type     seq_ff, seq_in;
   phase_type         phase_ff, phase_in;
   logic              r1_hold_ff, r1_hold_in;   // region-one test on current state
   logic              start_ff, start_in;       // request in work is a start
   logic [COLOR_W-1:0] color_ff, color_in;

   // ---------------- ellipse datapath ----------------
   logic [HW-1:0]          cxh_ff, cxh_in, cyh_ff, cyh_in;
   logic [CW-1:0]          rxh_ff, rxh_in, ryh_ff, ryh_in;
   logic [SQW-1:0]         a2_ff, a2_in, b2_ff, b2_in;
   logic [CW-1:0]          x_ff, x_in;
   logic [HW-1:0]          y_ff, y_in;
   logic [DEC_W-1:0]       dec_ff, dec_in;
   logic signed [DEC_PW-1:0] acc_ff, acc_in;
   logic signed [DEC_PW-1:0] hold_ff, hold_in;

   // ---------------- shared multiplier ----------------
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [DEC_PW-1:0] prod;

   // ---------------- derived terms ----------------
   logic                req_fire;
   logic                launch, emit_idle, more;
   mer_burst_ctl_type   burst_ctl;
   logic signed [HW:0]  y_s, ym1, ym2, two_my, three_my;
   logic [CW:0]         xp1, tx;
   logic [CW+1:0]       x2p3;
   logic [DEC_PW-1:0]   dsum;
   logic [DEC_W-1:0]    inc;
   logic [CW-1:0]       ax, ay, bx, by;

   function automatic logic signed [MUL_W-1:0] zx(input logic [MUL_W-2:0] v);
      return signed'({1'b0, v});
   endfunction

   assign ax = req_chan.corner_a_x;
   assign ay = req_chan.corner_a_y;
   assign bx = req_chan.corner_b_x;
   assign by = req_chan.corner_b_y;

   assign req_chan.ready = (seq_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign y_s      = signed'({1'b0, y_ff});
   assign ym1      = y_s - ONE_S;
   assign ym2      = y_s - TWO_S;
   assign two_my   = TWO_S - y_s;
   assign three_my = THREE_S - y_s;
   assign xp1      = {1'b0, x_ff} + (CW+1)'(1);
   assign tx       = {x_ff, 1'b1};                       // 2x+1
   assign x2p3     = {1'b0, x_ff, 1'b0} + (CW+2)'(3);    // 2x+3

   // another iteration remains after this request
   assign more = ((phase_ff == PH_R1) && r1_hold_ff) || (y_ff >= HW'(2));
   assign burst_ctl.two_pt   = start_ff;
   assign burst_ctl.finished = ~more;

   mer_mul #(
      .MUL_W  (MUL_W),
      .PROD_W (DEC_PW)
   ) u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   mer_emit #(
      .COORD_BITS (COORD_BITS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .launch        (launch),
      .ctl           (burst_ctl),
      .center_x_half (cxh_ff),
      .center_y_half (cyh_ff),
      .offset_x      (x_ff),
      .offset_y_half (y_ff),
      .color         (color_ff),
      .idle          (emit_idle),
      .rsp_chan      (rsp_chan)
   );

   always_comb begin
      seq_in     = seq_ff;
      phase_in   = phase_ff;
      r1_hold_in = r1_hold_ff;
      start_in   = start_ff;
      color_in   = csr_we ? csr_wdata : color_ff;
      cxh_in     = cxh_ff;
      cyh_in     = cyh_ff;
      rxh_in     = rxh_ff;
      ryh_in     = ryh_ff;
      a2_in      = a2_ff;
      b2_in      = b2_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      dec_in     = dec_ff;
      acc_in     = acc_ff;
      hold_in    = hold_ff;
      op_a       = '0;
      op_b       = '0;
      launch     = 1'b0;
      dsum       = '0;
      inc        = '0;

      unique case (seq_ff)
         S_IDLE: begin
            if (req_fire) begin
               start_in = (req_chan.command == CMD_START);
               if (req_chan.command == CMD_START) begin
                  // a start drops any ellipse in progress
                  cxh_in   = HW'(ax) + HW'(bx);
                  cyh_in   = HW'(ay) + HW'(by);
                  rxh_in   = (ax > bx) ? ax - bx : bx - ax;
                  ryh_in   = (ay > by) ? ay - by : by - ay;
                  x_in     = '0;
                  y_in     = HW'((ay > by) ? ay - by : by - ay);
                  phase_in = PH_R1;
                  seq_in   = S_ST_A2;
               end else begin
                  unique case (phase_ff)
                     PH_R1:   seq_in = r1_hold_ff ? S_R1_M1 : S_SW_1;
                     PH_R2:   seq_in = S_R2_CHK;
                     default: seq_in = S_IDLE;   // no ellipse: step is dropped
                  endcase
               end
            end
         end

         // ---- start: squares and the region-one start value ----
         S_ST_A2: begin
            op_a   = zx((MUL_W-1)'(rxh_ff));
            op_b   = zx((MUL_W-1)'(rxh_ff));
            seq_in = S_ST_B2;
         end
         S_ST_B2: begin
            op_a   = zx((MUL_W-1)'(ryh_ff));
            op_b   = zx((MUL_W-1)'(ryh_ff));
            a2_in  = prod[SQW-1:0];
            seq_in = S_ST_AB;
         end
         S_ST_AB: begin
            op_a   = zx((MUL_W-1)'(a2_ff));
            op_b   = zx((MUL_W-1)'(ryh_ff));
            b2_in  = prod[SQW-1:0];
            seq_in = S_ST_DEC;
         end
         S_ST_DEC: begin
            // 4p1 = floor((4B^2 - 2A^2 B + A^2) / 4)
            dsum   = DEC_PW'({b2_ff, 2'b00}) + DEC_PW'(a2_ff) - {prod[DEC_PW-2:0], 1'b0};
            dec_in = dsum[DEC_PW-1:2];
            seq_in = S_TST1;
         end

         // ---- region-one test: A^2(Y-1) > 2B^2(x+1) ----
         S_TST1: begin
            op_a   = zx((MUL_W-1)'(a2_ff));
            op_b   = MUL_W'(ym1);
            seq_in = S_TST2;
         end
         S_TST2: begin
            op_a    = zx((MUL_W-1)'(b2_ff));
            op_b    = zx((MUL_W-1)'(xp1));
            hold_in = prod;
            seq_in  = S_TST3;
         end
         S_TST3: begin
            r1_hold_in = (hold_ff > signed'({prod[DEC_PW-2:0], 1'b0}));
            seq_in     = S_LAUNCH;
         end

         // ---- region-one iteration ----
         S_R1_M1: begin
            op_a   = zx((MUL_W-1)'(b2_ff));
            op_b   = zx((MUL_W-1)'(x2p3));
            seq_in = S_R1_M2;
         end
         S_R1_M2: begin
            op_a   = zx((MUL_W-1)'(a2_ff));
            op_b   = MUL_W'(two_my);
            acc_in = prod;
            seq_in = S_R1_UPD;
         end
         S_R1_UPD: begin
            // decision nonnegative: y steps down as well
            inc = acc_ff[DEC_W-1:0] + (dec_ff[DEC_W-1] ? '0 : prod[DEC_W-1:0]);
            if (!dec_ff[DEC_W-1]) begin
               y_in = y_ff - HW'(2);
            end
            dec_in = dec_ff + inc;
            x_in   = x_ff + CW'(1);
            seq_in = S_TST1;
         end

         // ---- switch to region two: 4p2 from B^2(2x+1)^2 + A^2(Y-2)^2 - A^2 B^2 ----
         S_SW_1: begin
            op_a   = zx((MUL_W-1)'(tx));
            op_b   = zx((MUL_W-1)'(tx));
            seq_in = S_SW_2;
         end
         S_SW_2: begin
            op_a   = zx((MUL_W-1)'(b2_ff));
            op_b   = zx(prod[MUL_W-2:0]);
            seq_in = S_SW_3;
         end
         S_SW_3: begin
            op_a   = MUL_W'(ym2);
            op_b   = MUL_W'(ym2);
            acc_in = prod;
            seq_in = S_SW_4;
         end
         S_SW_4: begin
            op_a   = zx((MUL_W-1)'(a2_ff));
            op_b   = zx(prod[MUL_W-2:0]);
            seq_in = S_SW_5;
         end
         S_SW_5: begin
            op_a   = zx((MUL_W-1)'(a2_ff));
            op_b   = zx((MUL_W-1)'(b2_ff));
            acc_in = acc_ff + prod;
            seq_in = S_SW_6;
         end
         S_SW_6: begin
            dsum     = acc_ff - prod;
            dec_in   = dsum[DEC_PW-1:2];
            phase_in = PH_R2;
            seq_in   = S_R2_CHK;
         end

         // ---- region-two iteration ----
         S_R2_CHK: begin
            if (y_ff < HW'(2)) begin
               phase_in = PH_IDLE;   // nothing left: no pixels
               seq_in   = S_IDLE;
            end else begin
               op_a   = zx((MUL_W-1)'(a2_ff));
               op_b   = MUL_W'(three_my);
               seq_in = S_R2_M2;
            end
         end
         S_R2_M2: begin
            op_a   = zx((MUL_W-1)'(b2_ff));
            op_b   = zx((MUL_W-1)'(xp1));
            acc_in = prod;
            seq_in = S_R2_UPD;
         end
         S_R2_UPD: begin
            // decision negative: x steps out as well
            inc = acc_ff[DEC_W-1:0]
                + (dec_ff[DEC_W-1] ? {prod[DEC_W-2:0], 1'b0} : '0);
            if (dec_ff[DEC_W-1]) begin
               x_in = x_ff + CW'(1);
            end
            dec_in = dec_ff + inc;
            y_in   = y_ff - HW'(2);
            seq_in = S_LAUNCH;
         end

         S_LAUNCH: begin
            if (emit_idle) begin
               launch = 1'b1;
               if (!more) begin
                  phase_in = PH_IDLE;
               end
               seq_in = S_IDLE;
            end
         end

         default: seq_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= S_IDLE;
         phase_ff   <= PH_IDLE;
         r1_hold_ff <= 1'b0;
         start_ff   <= 1'b0;
         color_ff   <= '0;
      end else begin
         seq_ff     <= seq_in;
         phase_ff   <= phase_in;
         r1_hold_ff <= r1_hold_in;
         start_ff   <= start_in;
         color_ff   <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      cxh_ff  <= cxh_in;
      cyh_ff  <= cyh_in;
      rxh_ff  <= rxh_in;
      ryh_ff  <= ryh_in;
      a2_ff   <= a2_in;
      b2_ff   <= b2_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      dec_ff  <= dec_in;
      acc_ff  <= acc_in;
      hold_ff <= hold_in;
   end

endmodule

>>> dv/tb_midpoint_ellipse_rasterizer.sv
// Self-checking testbench for the midpoint ellipse rasterizer.
// Needs mer_pkg, mer_ifs (mer_req_if, mer_rsp_if) and the midpoint_ellipse_rasterizer RTL.
module tb_midpoint_ellipse_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   import mer_pkg::*;

   localparam int unsigned CB     = COORD_BITS_DEF;
   localparam int          CMAX   = (1 << CB) - 1;
   // the longest request to ready again is the region switch, plus a
   // four-pixel drain; give the block a comfortable margin to go quiet
   localparam int          SETTLE_CYCLES = 32;
   localparam int          RUN_LIMIT     = 200000;

   // ellipse progress as the predictor tracks it
   typedef enum logic [1:0] {
      ARC_IDLE = 2'd0,
      ARC_ONE  = 2'd1,
      ARC_TWO  = 2'd2
   } arc_phase_type;

   typedef struct {
      logic [CB-1:0]      x;
      logic [CB-1:0]      y;
      logic [COLOR_W-1:0] color;
      logic               last;
      logic               finished;
   } plotted_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [COLOR_W-1:0] csr_wdata = '0;

   mer_req_if #(.COORD_BITS(CB)) req_if ();
   mer_rsp_if #(.COORD_BITS(CB)) rsp_if ();

   midpoint_ellipse_rasterizer #(.COORD_BITS(CB)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Predicted block state: color register plus the ellipse being traced.
   // Widths follow the block: center and y offset in half pixels (13 bits),
   // radii and x offset 12 bits, decision value 48-bit two's complement
   // with two fractional bits.
   // ---------------------------------------------------------------------
   logic [COLOR_W-1:0] pixel_color = '0;
   logic [CB:0]        ctr_x_half  = '0;
   logic [CB:0]        ctr_y_half  = '0;
   logic [CB-1:0]      rad_x_half  = '0;
   logic [CB-1:0]      rad_y_half  = '0;
   logic [CB-1:0]      off_x       = '0;
   logic [CB:0]        off_y_half  = '0;
   logic [DEC_W-1:0]   decision    = '0;
   arc_phase_type      arc_phase   = ARC_IDLE;

   plotted_pixel_type pending_pixels[$];   // expected pixels, oldest first
   int             plotted_requests = 0; // requests that produced pixels
   int             fault_count      = 0;
   int             cycle_count      = 0;
   bit             req_jitter       = 1'b1;
   bit             rsp_jitter       = 1'b1;

   // ---------------------------------------------------------------------
   // Clock and watchdog
   // ---------------------------------------------------------------------
   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   // Region one keeps going while A^2(Y-1) > 2B^2(x+1), radii in half pixels.
   function automatic bit in_region_one();
      longint a, b;
      a = longint'(rad_x_half);
      b = longint'(rad_y_half);
      return a * a * (longint'(off_y_half) - 1) > 2 * b * b * (longint'(off_x) + 1);
   endfunction

   // Works out the pixels one accepted request causes and queues them.
   // Returns how many pixels were queued.
   function automatic int trace_ellipse(mer_cmd_type cmd, logic [CB-1:0] ax,
                                        logic [CB-1:0] ay, logic [CB-1:0] bx,
                                        logic [CB-1:0] by);
      logic [63:0]    a2, b2, inc, t, ym, acc;
      longint         hx[4], hy[4];
      longint         cx, cy, sx, sy, v;
      int             n;
      bit             done;
      plotted_pixel_type px;

      if (cmd == CMD_START) begin
         ctr_x_half = {1'b0, ax} + {1'b0, bx};
         ctr_y_half = {1'b0, ay} + {1'b0, by};
         rad_x_half = (ax > bx) ? ax - bx : bx - ax;
         rad_y_half = (ay > by) ? ay - by : by - ay;
         a2 = 64'(rad_x_half) * 64'(rad_x_half);
         b2 = 64'(rad_y_half) * 64'(rad_y_half);
         off_x = '0;
         off_y_half = {1'b0, rad_y_half};
         // 4*p1 = floor((4B^2 - 2A^2 B + A^2) / 4), arithmetic shift of 50 bits
         acc = 64'd4 * b2 - 64'd2 * a2 * 64'(rad_y_half) + a2;
         decision = acc[DEC_W+1:2];
         arc_phase = ARC_ONE;
         cx = longint'(ctr_x_half);
         cy = longint'(ctr_y_half);
         sy = longint'(off_y_half);
         hx[0] = cx;  hy[0] = cy + sy;
         hx[1] = cx;  hy[1] = cy - sy;
         n = 2;
      end else begin
         // step with nothing active is dropped silently
         if (arc_phase == ARC_IDLE)
            return 0;
         a2 = 64'(rad_x_half) * 64'(rad_x_half);
         b2 = 64'(rad_y_half) * 64'(rad_y_half);
         // slope test failed: reseed decision for region two, iterate there now
         if (arc_phase == ARC_ONE && !in_region_one()) begin
            t  = 64'd2 * 64'(off_x) + 64'd1;
            ym = 64'(off_y_half) - 64'd2;
            acc = b2 * t * t + a2 * ym * ym - a2 * b2;
            decision = acc[DEC_W+1:2];
            arc_phase = ARC_TWO;
         end
         if (arc_phase == ARC_ONE) begin
            inc = b2 * (64'd2 * 64'(off_x) + 64'd3);
            if (!decision[DEC_W-1]) begin
               inc = inc + a2 * (64'd2 - 64'(off_y_half));
               off_y_half = off_y_half - 2'd2;
            end
            decision = decision + inc[DEC_W-1:0];
            off_x = off_x + 1'b1;
         end else begin
            if (off_y_half < 2) begin
               arc_phase = ARC_IDLE;
               return 0;
            end
            inc = a2 * (64'd3 - 64'(off_y_half));
            if (decision[DEC_W-1]) begin
               inc = inc + 64'd2 * b2 * (64'(off_x) + 64'd1);
               off_x = off_x + 1'b1;
            end
            decision = decision + inc[DEC_W-1:0];
            off_y_half = off_y_half - 2'd2;
         end
         cx = longint'(ctr_x_half);
         cy = longint'(ctr_y_half);
         sx = 2 * longint'(off_x);
         sy = longint'(off_y_half);
         hx[0] = cx + sx;  hy[0] = cy + sy;
         hx[1] = cx - sx;  hy[1] = cy + sy;
         hx[2] = cx - sx;  hy[2] = cy - sy;
         hx[3] = cx + sx;  hy[3] = cy - sy;
         n = 4;
      end

      done = !((arc_phase == ARC_ONE && in_region_one()) || off_y_half >= 2);
      if (done)
         arc_phase = ARC_IDLE;

      // half-pixel to pixel: truncate toward zero, keep the low coordinate bits
      for (int k = 0; k < n; k++) begin
         v = hx[k] / 2;
         px.x = v[CB-1:0];
         v = hy[k] / 2;
         px.y = v[CB-1:0];
         px.color = pixel_color;
         px.last = (k == n - 1);
         px.finished = done;
         pending_pixels.push_back(px);
      end
      return n;
   endfunction

   // ---------------------------------------------------------------------
   // Pixel checker: every accepted pixel against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      plotted_pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel (%0d,%0d)", rsp_if.pixel_x, rsp_if.pixel_y);
            fault_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_x", want.x, rsp_if.pixel_x);
            check_field("pixel_y", want.y, rsp_if.pixel_y);
            check_field("color", want.color, rsp_if.color);
            check_field("last_of_step", want.last, rsp_if.last_of_step);
            check_field("finished", want.finished, rsp_if.finished);
         end
      end
   end

   // Pixel sink backpressure: a random stall cycle now and then.
   always @(posedge clock) begin
      rsp_if.ready <= !(rsp_jitter && $urandom_range(99) < 6);
   end

   // ---------------------------------------------------------------------
   // Request driver and housekeeping
   // ---------------------------------------------------------------------
   function automatic logic [CB-1:0] any_coord();
      return CB'($urandom);
   endfunction

   // Presents one request, holds it until accepted, then predicts it.
   // valid stays high afterwards so back-to-back requests need no bubble;
   // wait_drained drops it.
   task automatic send_request(mer_cmd_type cmd, logic [CB-1:0] ax, logic [CB-1:0] ay,
                               logic [CB-1:0] bx, logic [CB-1:0] by);
      if (req_jitter && $urandom_range(99) < 6) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.corner_a_x <= ax;
      req_if.corner_a_y <= ay;
      req_if.corner_b_x <= bx;
      req_if.corner_b_y <= by;
      do @(posedge clock); while (!req_if.ready);
      if (trace_ellipse(cmd, ax, ay, bx, by) > 0)
         plotted_requests++;
   endtask

   // corners are don't-care on a step, so they carry noise
   task automatic send_step();
      send_request(CMD_STEP, any_coord(), any_coord(), any_coord(), any_coord());
   endtask

   task automatic step_until_done(int max_steps);
      for (int i = 0; i < max_steps && arc_phase != ARC_IDLE; i++)
         send_step();
   endtask

   // Stop requesting, let every expected pixel arrive, then let the block
   // settle (an ignored step may still be in flight).
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_color(logic [COLOR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      pixel_color = value;
   endtask

   // Picks one axis of a small box: random base (sometimes pinned to an
   // edge of the coordinate range) and a short, often tiny, extent.
   function automatic void pick_span(output logic [CB-1:0] p, output logic [CB-1:0] q,
                                     input int max_len);
      int base, len;
      base = $urandom_range(CMAX);
      if ($urandom_range(9) == 0)
         base = $urandom_range(1) ? CMAX : 0;
      len = $urandom_range(1) ? $urandom_range(max_len) : $urandom_range(3);
      if (base + len > CMAX)
         len = -len;
      p = CB'(base);
      q = CB'(base + len);
      if ($urandom_range(1)) begin
         p = CB'(base + len);
         q = CB'(base);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Steps right after reset: nothing active, nothing may come out.
   task automatic test_steps_while_idle();
      send_step();
      send_step();
      wait_drained();
   endtask

   // Zero-size, flat and one-unit-high boxes finish on the start request
   // itself; the first pixels also carry the reset color.
   task automatic test_degenerate_boxes();
      send_request(CMD_START, 12'd5, 12'd7, 12'd5, 12'd7);
      send_request(CMD_START, 12'd100, 12'd50, 12'd300, 12'd50);
      send_step();   // ellipse already done, dropped
      wait_drained();
      write_color(24'hFF_FFFF);
      send_request(CMD_START, 12'd4095, 12'd1, 12'd4090, 12'd0);
      wait_drained();
   endtask

   // Full-range corners, both orders; a new start drops the live ellipse.
   task automatic test_corner_extremes();
      send_request(CMD_START, 12'd0, 12'd0, 12'd4095, 12'd4095);
      send_step();
      send_step();
      send_request(CMD_START, 12'd4095, 12'd0, 12'd0, 12'd4095);
      send_step();
      wait_drained();
   endtask

   // One small ellipse traced end to end through the region switch.
   task automatic test_small_ellipse();
      write_color(24'h3C_A5_5A);
      send_request(CMD_START, 12'd0, 12'd0, 12'd6, 12'd4);
      step_until_done(50);
      wait_drained();
   endtask

   // Sub-pixel-wide box on the left edge: mirrored x goes below zero and
   // must truncate toward zero.
   task automatic test_thin_box();
      write_color(24'h00_0000);
      send_request(CMD_START, 12'd0, 12'd0, 12'd1, 12'd12);
      step_until_done(50);
      wait_drained();
   endtask

   // Mostly complete ellipses with random small boxes; some huge boxes
   // for a few steps, some abandoned by a new start, some stray steps.
   // Color changes every few dozen requests while quiet.
   task automatic test_random_ellipses(int requests);
      int stop_at, recolor_at;
      logic [CB-1:0] ax, ay, bx, by;
      stop_at = plotted_requests + requests;
      recolor_at = plotted_requests + 60;
      while (plotted_requests < stop_at) begin
         if (plotted_requests >= recolor_at) begin
            wait_drained();
            write_color(COLOR_W'($urandom));
            recolor_at += 60;
         end
         if ($urandom_range(99) < 12) begin
            send_request(CMD_START, any_coord(), any_coord(), any_coord(), any_coord());
            repeat ($urandom_range(6)) send_step();
         end else begin
            pick_span(ax, bx, 40);
            pick_span(ay, by, 30);
            send_request(CMD_START, ax, ay, bx, by);
            if ($urandom_range(99) < 80) begin
               step_until_done(200);
               if ($urandom_range(9) == 0)
                  send_step();
            end else begin
               repeat ($urandom_range(1, 8)) send_step();
            end
         end
      end
      wait_drained();
   endtask

   // Same traffic with both sides running flat out.
   task automatic test_no_idle_stretch();
      req_jitter = 1'b0;
      rsp_jitter = 1'b0;
      test_random_ellipses(80);
      req_jitter = 1'b1;
      rsp_jitter = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_START;
      req_if.corner_a_x <= '0;
      req_if.corner_a_y <= '0;
      req_if.corner_b_x <= '0;
      req_if.corner_b_y <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_steps_while_idle();
      test_degenerate_boxes();
      test_corner_extremes();
      test_small_ellipse();
      test_thin_box();
      test_random_ellipses(380);
      test_no_idle_stretch();

      wait_drained();
      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
